@@ hw/rtl/hwa_pkg.sv @@
// Shared types, constants and coefficient table builder for the Hamming window block.
package hwa_pkg;

  // Phase resolution of the coefficient table.
  localparam int PHASE_BITS  = 10;
  localparam int PHASE_DEPTH = 1 << PHASE_BITS;
  localparam int DIV_CNT_W   = $clog2(PHASE_BITS);

  // Coefficient is unsigned Q1.15, at most 1.0.
  localparam int COEF_W    = 16;
  localparam int COEF_FRAC = 15;

  localparam logic [63:0] ONE_Q62     = 64'd1 << 62;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
  localparam int          TAYLOR_TERMS = 27;
  localparam logic [63:0] OFFSET_Q58  = 64'd27 << 58;
  localparam logic [63:0] ROUND_Q     = 64'd25 << 43;
  localparam logic [63:0] SCALE_Q     = 64'd25 << 44;

  typedef logic [COEF_W-1:0] coef_rom_t [PHASE_DEPTH];

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_LOOKUP,
    ST_MULTIPLY,
    ST_DELIVER
  } hwa_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic rom_read;
    logic mul;
    logic push;
  } hwa_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } hwa_status_t;

  // Q1.15 coefficient 0.54 - 0.46*cos(2*pi*p/2^PHASE_BITS), evaluated by a
  // quadrant-reduced Taylor series in Q2.62, elaboration time only.
  function automatic logic [COEF_W-1:0] window_coef(input int unsigned p);
    int unsigned  quad;
    logic [63:0]  r;
    logic [127:0] wide;
    logic [63:0]  x;
    logic [63:0]  t;
    logic [63:0]  cpos;
    logic [63:0]  cneg;
    logic [63:0]  spos;
    logic [63:0]  sneg;
    logic [63:0]  mag;
    logic [63:0]  c58;
    logic [63:0]  v;
    logic [63:0]  q;
    logic         negative;
    quad = (p >> (PHASE_BITS - 2)) & 3;
    r    = 64'(p) & ((64'd1 << (PHASE_BITS - 2)) - 64'd1);
    wide = 128'(HALF_PI_Q62) * 128'(r);
    x    = 64'(wide >> (PHASE_BITS - 2));
    t    = ONE_Q62;
    cpos = ONE_Q62;
    cneg = '0;
    spos = '0;
    sneg = '0;
    for (int unsigned K = 1; K <= TAYLOR_TERMS; K++) begin
      wide = 128'(t) * 128'(x);
      t    = 64'(wide >> 62) / 64'(K);
      if (K[0]) begin
        if (K[1]) sneg = sneg + t;
        else      spos = spos + t;
      end else begin
        if (K[1]) cneg = cneg + t;
        else      cpos = cpos + t;
      end
    end
    if (quad[0]) mag = (spos > sneg) ? spos - sneg : 64'd0;
    else         mag = (cpos > cneg) ? cpos - cneg : 64'd0;
    negative = (quad == 1) || (quad == 2);
    c58 = mag >> 4;
    v   = negative ? OFFSET_Q58 + 64'd23 * c58 : OFFSET_Q58 - 64'd23 * c58;
    q   = (v + ROUND_Q) / SCALE_Q;
    return COEF_W'(q);
  endfunction

  function automatic coef_rom_t build_coef_rom();
    coef_rom_t rom;
    for (int unsigned n = 0; n < PHASE_DEPTH; n++) begin
      rom[n] = window_coef(n);
    end
    return rom;
  endfunction

endpackage

@@ hw/rtl/hwa_ctrl.sv @@
// Sequencing state machine for the Hamming window block.
module hwa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hwa_pkg::hwa_status_t status,
  output hwa_pkg::hwa_cmd_t    cmd
);

  hwa_pkg::hwa_state_t state;
  hwa_pkg::hwa_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hwa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      hwa_pkg::ST_IDLE: begin
        if (in_valid) state_next = hwa_pkg::ST_DIVIDE;
      end
      hwa_pkg::ST_DIVIDE: begin
        if (status.div_last) state_next = hwa_pkg::ST_LOOKUP;
      end
      hwa_pkg::ST_LOOKUP: begin
        state_next = hwa_pkg::ST_MULTIPLY;
      end
      hwa_pkg::ST_MULTIPLY: begin
        state_next = hwa_pkg::ST_DELIVER;
      end
      hwa_pkg::ST_DELIVER: begin
        if (status.out_free) state_next = hwa_pkg::ST_IDLE;
      end
      default: begin
        state_next = hwa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      hwa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      hwa_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      hwa_pkg::ST_LOOKUP: begin
        cmd.rom_read = 1'b1;
      end
      hwa_pkg::ST_MULTIPLY: begin
        cmd.mul = 1'b1;
      end
      hwa_pkg::ST_DELIVER: begin
        cmd.push = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ hw/rtl/hwa_datapath.sv @@
// Index tracking, phase divider, coefficient ROM, multiplier and output register.
module hwa_datapath #(
  parameter int MAX_LENGTH  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [10:0]                   cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  hwa_pkg::hwa_cmd_t             cmd,
  output hwa_pkg::hwa_status_t          status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] windowed_sample,
  output logic                          frame_end
);

  localparam int IDX_W  = $clog2(MAX_LENGTH);
  localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
  localparam int PB     = hwa_pkg::PHASE_BITS;
  localparam int CNT_W  = hwa_pkg::DIV_CNT_W;
  localparam int PROD_W = SAMPLE_BITS + hwa_pkg::COEF_W + 1;
  localparam logic [CNT_W-1:0]  DivLast   = CNT_W'(PB - 1);
  localparam logic [PROD_W-1:0] RoundHalf = PROD_W'(1) << (hwa_pkg::COEF_FRAC - 1);
  localparam hwa_pkg::coef_rom_t CoefRom = hwa_pkg::build_coef_rom();

  logic [10:0]                   window_length;
  logic [IDX_W-1:0]              sample_index;
  logic signed [SAMPLE_BITS-1:0] held_sample;
  logic                          held_last;
  logic [LEN_W-1:0]              rem;
  logic [PB-1:0]                 quo;
  logic [CNT_W-1:0]              div_cnt;
  logic [hwa_pkg::COEF_W-1:0]    coef;
  logic signed [PROD_W-1:0]      prod;

  logic [31:0]      len_wide;
  logic [LEN_W-1:0] len;
  logic [IDX_W-1:0] idx_eff;
  logic             is_last;
  logic [LEN_W:0]   rem_shift;
  logic             rem_ge;
  logic [PROD_W-1:0] rounded;

  // Zero acts as one, oversize clamps to the maximum.
  always_comb begin
    if (window_length == 11'd0) begin
      len_wide = 32'd1;
    end else if (32'(window_length) > 32'(MAX_LENGTH)) begin
      len_wide = 32'(MAX_LENGTH);
    end else begin
      len_wide = 32'(window_length);
    end
    len     = LEN_W'(len_wide);
    idx_eff = (LEN_W'(sample_index) < len) ? sample_index : '0;
    is_last = (LEN_W'(idx_eff) == len - LEN_W'(1));
  end

  // Restoring divider step: remainder stays below len.
  assign rem_shift = {rem, 1'b0};
  assign rem_ge    = rem_shift >= {1'b0, len};
  assign rounded   = prod + RoundHalf;

  assign status.div_last = (div_cnt == DivLast);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= 11'd1024;
      sample_index  <= '0;
    end else if (cfg_write) begin
      window_length <= cfg_data;
      sample_index  <= '0;
    end else if (cmd.load) begin
      sample_index <= is_last ? '0 : idx_eff + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held_sample <= sample;
      held_last   <= is_last;
      rem         <= LEN_W'(idx_eff);
      quo         <= '0;
      div_cnt     <= '0;
    end else if (cmd.div_step) begin
      rem     <= rem_ge ? LEN_W'(rem_shift - {1'b0, len}) : rem_shift[LEN_W-1:0];
      quo     <= {quo[PB-2:0], rem_ge};
      div_cnt <= div_cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rom_read) begin
      coef <= CoefRom[quo];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= PROD_W'(held_sample * $signed({1'b0, coef}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      windowed_sample <= rounded[hwa_pkg::COEF_FRAC +: SAMPLE_BITS];
      frame_end       <= held_last;
    end
  end

endmodule

@@ hw/rtl/hamming_window_apply.sv @@
// Top level of the Hamming window block: controller plus datapath.
// Sequence: an accepted word goes through PHASE_BITS steps of the bit-serial phase divider,
// then the ROM read, the multiply and the output load, before it shows on the output.
// A new word is taken only after the last one is loaded into the output register, and that
// load waits while the output is full; a finished word waits there while the next one is taken.
// Reset (rst, synchronous): window_length = 1024, sample index 0, output empty.
module hamming_window_apply #(
  parameter int MAX_LENGTH  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // length register write
  input  logic                          cfg_write,
  input  logic [10:0]                   cfg_data,
  // input word
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  // output word
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] windowed_sample,
  output logic                          frame_end
);

  hwa_pkg::hwa_cmd_t    cmd;
  hwa_pkg::hwa_status_t status;

  // Controller: idle -> divide -> lookup -> multiply -> deliver.
  hwa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: phase = floor(i * 2^PHASE_BITS / len) by restoring division,
  // coefficient from a constant ROM, then rounded Q1.15 scaling.
  hwa_datapath #(
    .MAX_LENGTH  (MAX_LENGTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .sample          (sample),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .windowed_sample (windowed_sample),
    .frame_end       (frame_end)
  );

endmodule
